>>> design/cfp_pkg.sv
package cfp_pkg;

  localparam int MAX_DATA_DEF = 32;
  localparam logic [7:0] START_RESET = 8'hAA;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_SUM = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] cmd_type;
    logic [7:0] frame_length;
    logic       bank;
  } frame_cmd_t;

  typedef struct packed {
    logic       en;
    logic       bank;
    logic [7:0] pos;
    logic [7:0] data;
  } buf_wr_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } buf_rel_t;

endpackage

>>> design/cfp_front.sv
module cfp_front #(
  parameter int MAX_DATA = cfp_pkg::MAX_DATA_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_rx_byte,
  output cfp_pkg::buf_wr_t    buf_wr,
  input  cfp_pkg::buf_rel_t   buf_rel,
  output logic                push,
  output cfp_pkg::frame_cmd_t push_cmd,
  input  logic                push_ready
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_TYPE,
    PH_LEN,
    PH_DATA,
    PH_CHECK
  } phase_t;

  localparam logic [7:0] MAX_LEN = 8'(MAX_DATA);

  phase_t     phase_r;
  logic [7:0] marker_r;
  logic [7:0] type_r;
  logic [7:0] len_r;
  logic [7:0] pos_r;
  logic [7:0] sum_r;
  logic       bank_r;
  logic [1:0] busy_r;

  logic       accept;
  logic [7:0] pos_nxt;
  logic [7:0] sum_nxt;
  logic       good_data;

  assign in_stall = ((phase_r == PH_DATA) && busy_r[bank_r]) ||
                    ((phase_r == PH_CHECK) && !push_ready);
  assign accept   = in_valid && !in_stall;
  assign pos_nxt  = pos_r + 8'd1;
  assign sum_nxt  = sum_r + in_rx_byte;

  assign buf_wr.en   = accept && (phase_r == PH_DATA) && (pos_r < MAX_LEN);
  assign buf_wr.bank = bank_r;
  assign buf_wr.pos  = pos_r;
  assign buf_wr.data = in_rx_byte;

  always_comb begin
    push_cmd.cmd_type     = type_r;
    push_cmd.frame_length = len_r;
    push_cmd.bank         = bank_r;
    if (len_r > MAX_LEN) begin
      push_cmd.status = cfp_pkg::ST_TOO_LONG;
    end else if (in_rx_byte != sum_r) begin
      push_cmd.status = cfp_pkg::ST_BAD_SUM;
    end else begin
      push_cmd.status = cfp_pkg::ST_OK;
    end
  end

  assign push      = accept && (phase_r == PH_CHECK);
  assign good_data = (push_cmd.status == cfp_pkg::ST_OK) && (len_r != 8'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      marker_r <= cfp_pkg::START_RESET;
      type_r   <= 8'd0;
      len_r    <= 8'd0;
      pos_r    <= 8'd0;
      sum_r    <= 8'd0;
      bank_r   <= 1'b0;
      busy_r   <= 2'b00;
    end else begin
      if (cfg_wr_en) begin
        marker_r <= cfg_wr_data;
      end
      if (buf_rel.valid) begin
        busy_r[buf_rel.bank] <= 1'b0;
      end
      if (accept) begin
        unique case (phase_r)
          PH_HUNT: begin
            if (in_rx_byte == marker_r) begin
              sum_r   <= 8'd0;
              phase_r <= PH_TYPE;
            end
          end
          PH_TYPE: begin
            type_r  <= in_rx_byte;
            sum_r   <= sum_nxt;
            phase_r <= PH_LEN;
          end
          PH_LEN: begin
            len_r   <= in_rx_byte;
            sum_r   <= sum_nxt;
            pos_r   <= 8'd0;
            phase_r <= (in_rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
          end
          PH_DATA: begin
            sum_r <= sum_nxt;
            pos_r <= pos_nxt;
            if (pos_nxt >= len_r) begin
              phase_r <= PH_CHECK;
            end
          end
          PH_CHECK: begin
            if (good_data) begin
              busy_r[bank_r] <= 1'b1;
              bank_r         <= ~bank_r;
            end
            phase_r <= PH_HUNT;
          end
          default: begin
            phase_r <= PH_HUNT;
          end
        endcase
      end
    end
  end

  // a frame is only stored into a bank the back end no longer reads
  a_wr_free_bank: assert property (@(posedge clk) disable iff (!rst_n)
    buf_wr.en |-> !busy_r[bank_r])
    else $error("payload write into busy bank");

  a_push_free_bank: assert property (@(posedge clk) disable iff (!rst_n)
    (push && good_data) |=> busy_r[$past(bank_r)])
    else $error("bank not marked busy after good frame");

endmodule

>>> design/cfp_queue.sv
module cfp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cfp_pkg::frame_cmd_t push_cmd,
  output logic                push_ready,
  output logic                head_valid,
  output cfp_pkg::frame_cmd_t head_cmd,
  input  logic                pop
);

  cfp_pkg::frame_cmd_t slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign push_ready = (count_r != 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_cmd   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push && push_ready) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop && head_valid) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push && push_ready, pop && head_valid})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("request queue count out of range");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty request queue");

endmodule

>>> design/cfp_back.sv
module cfp_back #(
  parameter int MAX_DATA = cfp_pkg::MAX_DATA_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cfp_pkg::buf_wr_t    buf_wr,
  output cfp_pkg::buf_rel_t   buf_rel,
  input  logic                head_valid,
  input  cfp_pkg::frame_cmd_t head_cmd,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [7:0]          out_cmd_type,
  output logic [7:0]          out_frame_length,
  output logic [4:0]          out_data_index,
  output logic [7:0]          out_data_byte,
  output logic                out_last
);

  localparam int AW        = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
  localparam int MEM_DEPTH = 2 ** (AW + 1);

  logic [7:0] mem_r [MEM_DEPTH];

  logic [7:0] idx_r;

  // read stage
  logic       s1_valid_r;
  logic [1:0] s1_status_r;
  logic [7:0] s1_type_r;
  logic [7:0] s1_len_r;
  logic [4:0] s1_idx_r;
  logic       s1_use_mem_r;
  logic       s1_last_r;
  logic [7:0] rd_data_r;

  // output register
  logic       out_valid_r;
  logic [1:0] out_status_r;
  logic [7:0] out_type_r;
  logic [7:0] out_len_r;
  logic [4:0] out_idx_r;
  logic [7:0] out_data_r;
  logic       out_last_r;

  logic       good;
  logic       last_issue;
  logic       s1_adv;
  logic       issue;
  logic [7:0] idx_nxt;

  assign good       = (head_cmd.status == cfp_pkg::ST_OK) && (head_cmd.frame_length != 8'd0);
  assign idx_nxt    = idx_r + 8'd1;
  assign last_issue = !good || (idx_nxt == head_cmd.frame_length);
  assign s1_adv     = s1_valid_r && (!out_valid_r || !out_stall);
  assign issue      = head_valid && (!s1_valid_r || s1_adv);
  assign pop        = issue && last_issue;

  assign buf_rel.valid = issue && last_issue && good;
  assign buf_rel.bank  = head_cmd.bank;

  always_ff @(posedge clk) begin
    if (buf_wr.en) begin
      mem_r[{buf_wr.bank, buf_wr.pos[AW-1:0]}] <= buf_wr.data;
    end
    if (issue) begin
      rd_data_r <= mem_r[{head_cmd.bank, idx_r[AW-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_status_r  <= head_cmd.status;
      s1_type_r    <= head_cmd.cmd_type;
      s1_len_r     <= head_cmd.frame_length;
      s1_idx_r     <= good ? idx_r[4:0] : 5'd0;
      s1_use_mem_r <= good;
      s1_last_r    <= last_issue;
    end
    if (s1_adv) begin
      out_status_r <= s1_status_r;
      out_type_r   <= s1_type_r;
      out_len_r    <= s1_len_r;
      out_idx_r    <= s1_idx_r;
      out_data_r   <= s1_use_mem_r ? rd_data_r : 8'd0;
      out_last_r   <= s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 8'd0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (issue) begin
        idx_r <= last_issue ? 8'd0 : idx_nxt;
      end
      if (issue) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_cmd_type     = out_type_r;
  assign out_frame_length = out_len_r;
  assign out_data_index   = out_idx_r;
  assign out_data_byte    = out_data_r;
  assign out_last         = out_last_r;

  // error requests always come out as a single last result
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != cfp_pkg::ST_OK)) |->
      (out_last_r && (out_idx_r == 5'd0) && (out_data_r == 8'd0)))
    else $error("error result not single");

  a_idx_reset_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (idx_r == 8'd0))
    else $error("result index not cleared after request");

endmodule

>>> design/command_frame_parser_unit.sv
// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+---------------------------------------
// in        | input     | in_valid / in_stall  | in_rx_byte
// out       | output    | out_valid / out_stall| out_status, out_cmd_type, out_frame_length,
//           |           |                      | out_data_index, out_data_byte, out_last
// cfg       | input     | cfg_wr_en            | cfg_wr_data (start marker)
//
// one input byte per cycle unless in_stall is high; results leave at one per
// cycle while out_stall is low, via a payload read and an output register
// two payload banks and a two-entry request queue let a new frame be parsed
// while the previous one is still being sent
// in_stall rises on a data byte while its bank is still being read, and on a
// checksum byte while the request queue is full
// rst_n is synchronous; start marker resets to 0xaa
module command_frame_parser_unit #(
  parameter int MAX_DATA = cfp_pkg::MAX_DATA_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [7:0] out_cmd_type,
  output logic [7:0] out_frame_length,
  output logic [4:0] out_data_index,
  output logic [7:0] out_data_byte,
  output logic       out_last
);

  cfp_pkg::buf_wr_t    buf_wr;
  cfp_pkg::buf_rel_t   buf_rel;
  cfp_pkg::frame_cmd_t push_cmd;
  cfp_pkg::frame_cmd_t head_cmd;
  logic                push;
  logic                push_ready;
  logic                head_valid;
  logic                pop;

  cfp_front #(
    .MAX_DATA(MAX_DATA)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .buf_wr     (buf_wr),
    .buf_rel    (buf_rel),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  cfp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .push_ready(push_ready),
    .head_valid(head_valid),
    .head_cmd  (head_cmd),
    .pop       (pop)
  );

  cfp_back #(
    .MAX_DATA(MAX_DATA)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .buf_wr          (buf_wr),
    .buf_rel         (buf_rel),
    .head_valid      (head_valid),
    .head_cmd        (head_cmd),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_cmd_type    (out_cmd_type),
    .out_frame_length(out_frame_length),
    .out_data_index  (out_data_index),
    .out_data_byte   (out_data_byte),
    .out_last        (out_last)
  );

endmodule
